### hw/rtl/circular_buffer_deque_core_defines.svh
// Assertion macros used by the port-level checker of the deque core.
// No dependencies; the user supplies clock, reset and the property terms.
`ifndef CIRCULAR_BUFFER_DEQUE_CORE_DEFINES_SVH
`define CIRCULAR_BUFFER_DEQUE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CBD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/cbd_pkg.sv
// Shared types, constants and index helpers for the circular deque core.
// No dependencies; used by the slot memory, the top level and the checker.
package cbd_pkg;

	localparam int DEPTH     = 8;
	localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int VAL_W     = 32;
	localparam int KIND_W    = 2;
	localparam int STATUS_W  = 2;
	localparam int OUT_CNT_W = 4;

	typedef logic [IDX_W-1:0]        idx_t;
	typedef logic [CNT_W-1:0]        cnt_t;
	typedef logic signed [VAL_W-1:0] val_t;
	typedef logic [KIND_W-1:0]       kind_t;
	typedef logic [STATUS_W-1:0]     status_t;

	localparam kind_t KIND_PUSH_FRONT = 2'd0;
	localparam kind_t KIND_PUSH_BACK  = 2'd1;
	localparam kind_t KIND_POP_FRONT  = 2'd2;
	localparam kind_t KIND_POP_BACK   = 2'd3;

	localparam status_t STAT_DONE  = 2'd0;
	localparam status_t STAT_FULL  = 2'd1;
	localparam status_t STAT_EMPTY = 2'd2;

	typedef struct packed {
		logic wr_en;
		idx_t wr_addr;
		val_t wr_data;
		logic rd_en;
		idx_t rd_addr;
	} ram_req_t;

	function automatic idx_t wrap_inc(input idx_t i);
		return (i == IDX_W'(DEPTH - 1)) ? '0 : i + IDX_W'(1);
	endfunction

	function automatic idx_t wrap_dec(input idx_t i);
		return (i == '0) ? IDX_W'(DEPTH - 1) : i - IDX_W'(1);
	endfunction

endpackage

### hw/rtl/cbd_ram.sv
// Slot memory of the deque: one write port, one read port, registered read data.
// Depends on cbd_pkg for the depth, index and value types.
module cbd_ram (
	input  logic              clk,
	input  cbd_pkg::ram_req_t req,
	output cbd_pkg::val_t     rd_data
);

	cbd_pkg::val_t mem [cbd_pkg::DEPTH];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end

endmodule

### hw/rtl/circular_buffer_deque_core.sv
// Fixed-capacity double-ended queue held in a circular slot memory; each input transfer
// pushes or pops at either end and yields exactly one result transfer. A push, a rejected
// request, or a pop that empties the deque goes straight into the result register; a pop that
// leaves entries first passes through the read state, because the new end value comes from the
// slot memory, whose read data is registered. The front and back values are cached in
// registers, so no other operation reads the memory. A new request is taken once no slot
// read is pending and the result register is empty or is being taken in the same cycle.
// Depends on cbd_pkg and cbd_ram.
module circular_buffer_deque_core (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  cbd_pkg::kind_t          kind,
	input  logic signed [31:0]      push_value,
	output logic                    out_valid,
	input  logic                    out_stall,
	output cbd_pkg::status_t        status,
	output logic signed [31:0]      popped_value,
	output logic signed [31:0]      front_value,
	output logic signed [31:0]      back_value,
	output logic [3:0]              entry_count,
	output logic                    is_empty,
	output logic                    is_full
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_READ = 1'b1;

	logic state_q;

	cbd_pkg::idx_t head_q, head_d;
	cbd_pkg::idx_t tail_q, tail_d;
	cbd_pkg::cnt_t count_q, count_d;
	cbd_pkg::val_t front_q, front_d;
	cbd_pkg::val_t back_q, back_d;
	logic refill_front_q, refill_front_d;
	logic go_read;

	cbd_pkg::ram_req_t ram_req;
	cbd_pkg::val_t     rd_data;

	cbd_pkg::status_t res_status;
	cbd_pkg::val_t    res_popped;
	cbd_pkg::val_t    res_front;
	cbd_pkg::val_t    res_back;
	cbd_pkg::cnt_t    res_count;
	logic             load_out;
	logic             in_take;

	logic             out_valid_q;
	cbd_pkg::status_t status_q;
	cbd_pkg::val_t    popped_q;
	cbd_pkg::val_t    front_out_q;
	cbd_pkg::val_t    back_out_q;
	cbd_pkg::cnt_t    count_out_q;

	cbd_ram u_ram (
		.clk     (clk),
		.req     (ram_req),
		.rd_data (rd_data)
	);

	assign in_stall = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign in_take  = in_valid && !in_stall;

	always_comb begin
		head_d         = head_q;
		tail_d         = tail_q;
		count_d        = count_q;
		front_d        = front_q;
		back_d         = back_q;
		refill_front_d = refill_front_q;
		go_read        = 1'b0;
		ram_req        = '0;
		res_status     = cbd_pkg::STAT_DONE;
		res_popped     = '0;

		if (state_q == S_READ) begin
			if (refill_front_q) begin
				front_d = rd_data;
			end else begin
				back_d = rd_data;
			end
		end else if (in_take) begin
			if (kind inside {cbd_pkg::KIND_PUSH_FRONT, cbd_pkg::KIND_PUSH_BACK}) begin
				if (count_q == cbd_pkg::CNT_W'(cbd_pkg::DEPTH)) begin
					res_status = cbd_pkg::STAT_FULL;
				end else if (count_q == '0) begin
					ram_req.wr_en   = 1'b1;
					ram_req.wr_addr = head_q;
					ram_req.wr_data = push_value;
					tail_d          = head_q;
					count_d         = cbd_pkg::CNT_W'(1);
					front_d         = push_value;
					back_d          = push_value;
				end else if (kind == cbd_pkg::KIND_PUSH_FRONT) begin
					head_d          = cbd_pkg::wrap_dec(head_q);
					ram_req.wr_en   = 1'b1;
					ram_req.wr_addr = head_d;
					ram_req.wr_data = push_value;
					count_d         = count_q + cbd_pkg::CNT_W'(1);
					front_d         = push_value;
				end else begin
					tail_d          = cbd_pkg::wrap_inc(tail_q);
					ram_req.wr_en   = 1'b1;
					ram_req.wr_addr = tail_d;
					ram_req.wr_data = push_value;
					count_d         = count_q + cbd_pkg::CNT_W'(1);
					back_d          = push_value;
				end
			end else begin
				if (count_q == '0) begin
					res_status = cbd_pkg::STAT_EMPTY;
				end else begin
					res_popped = (kind == cbd_pkg::KIND_POP_FRONT) ? front_q : back_q;
					count_d    = count_q - cbd_pkg::CNT_W'(1);
					if (count_q == cbd_pkg::CNT_W'(1)) begin
						head_d = '0;
						tail_d = '0;
					end else if (kind == cbd_pkg::KIND_POP_FRONT) begin
						head_d          = cbd_pkg::wrap_inc(head_q);
						ram_req.rd_en   = 1'b1;
						ram_req.rd_addr = head_d;
						refill_front_d  = 1'b1;
						go_read         = 1'b1;
					end else begin
						tail_d          = cbd_pkg::wrap_dec(tail_q);
						ram_req.rd_en   = 1'b1;
						ram_req.rd_addr = tail_d;
						refill_front_d  = 1'b0;
						go_read         = 1'b1;
					end
				end
			end
		end

		res_count = count_d;
		res_front = (count_d == '0) ? '0 : front_d;
		res_back  = (count_d == '0) ? '0 : back_d;
		load_out  = (state_q == S_READ) || (in_take && !go_read);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			head_q         <= '0;
			tail_q         <= '0;
			count_q        <= '0;
			refill_front_q <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			head_q         <= head_d;
			tail_q         <= tail_d;
			count_q        <= count_d;
			refill_front_q <= refill_front_d;
			if (state_q == S_READ) begin
				state_q <= S_IDLE;
			end else if (go_read) begin
				state_q <= S_READ;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// The popped value of a pop that reads the slot memory is parked in popped_q at the request transfer.
	always_ff @(posedge clk) begin
		front_q <= front_d;
		back_q  <= back_d;
		if (in_take) begin
			popped_q <= res_popped;
		end
		if (load_out) begin
			status_q    <= res_status;
			front_out_q <= res_front;
			back_out_q  <= res_back;
			count_out_q <= res_count;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign popped_value = popped_q;
	assign front_value  = front_out_q;
	assign back_value   = back_out_q;
	assign entry_count  = cbd_pkg::OUT_CNT_W'(count_out_q);
	assign is_empty     = (count_out_q == '0);
	assign is_full      = (count_out_q == cbd_pkg::CNT_W'(cbd_pkg::DEPTH));

endmodule

### hw/rtl/cbd_checker.sv
// Port-level checker for the deque core, attached to it by the bind below.
// Depends on cbd_pkg and the assertion macros in circular_buffer_deque_core_defines.svh.
`include "circular_buffer_deque_core_defines.svh"

module cbd_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_stall,
	input cbd_pkg::status_t    status,
	input logic signed [31:0]  popped_value,
	input logic signed [31:0]  front_value,
	input logic signed [31:0]  back_value,
	input logic [3:0]          entry_count,
	input logic                is_empty,
	input logic                is_full
);

	`CBD_ASSERT_NOW(a_empty_result_zero, clk, arst_n, out_valid && is_empty, entry_count == '0 && front_value == '0 && back_value == '0, "Empty result shows a nonzero count or end value.")
	`CBD_ASSERT_NOW(a_reject_pops_nothing, clk, arst_n, out_valid && status != cbd_pkg::STAT_DONE, popped_value == '0, "Rejected request reports a popped value.")
	`CBD_ASSERT_NOW(a_full_count, clk, arst_n, out_valid && is_full, entry_count == cbd_pkg::OUT_CNT_W'(cbd_pkg::DEPTH) && !is_empty, "Full flag disagrees with the entry count.")
	`CBD_ASSERT_NEXT(a_stalled_result_holds, clk, arst_n, out_valid && out_stall, out_valid && $stable(status) && $stable(popped_value) && $stable(entry_count), "Stalled result transfer changed.")

endmodule

bind circular_buffer_deque_core cbd_checker u_cbd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.status       (status),
	.popped_value (popped_value),
	.front_value  (front_value),
	.back_value   (back_value),
	.entry_count  (entry_count),
	.is_empty     (is_empty),
	.is_full      (is_full)
);

### test/circular_buffer_deque_core_check.sv
// Checker for the circular deque core: it watches both handshake channels, keeps its own deque
// model, and compares every result transfer against the oldest predicted result.
// Depends on cbd_pkg.
`timescale 1ns / 1ps

module circular_buffer_deque_core_check import cbd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_stall,
	input  kind_t            kind,
	input  val_t             push_value,
	input  logic             out_valid,
	input  logic             out_stall,
	input  status_t          status,
	input  val_t             popped_value,
	input  val_t             front_value,
	input  val_t             back_value,
	input  logic [3:0]       entry_count,
	input  logic             is_empty,
	input  logic             is_full,
	output int               errors,
	output int               pending,
	output int               results_seen,
	output int               rejects_seen
);

	typedef struct packed {
		status_t    status;
		val_t       popped;
		val_t       front;
		val_t       back;
		logic [3:0] count;
		logic       empty;
		logic       full;
	} deque_result_t;

	val_t          slot_mem [DEPTH];
	idx_t          head_idx;
	idx_t          tail_idx;
	cnt_t          held;
	deque_result_t expected_q [$];
	deque_result_t want;
	int            err_count;
	int            result_count;
	int            reject_count;

	function automatic idx_t idx_up(input idx_t i);
		return idx_t'((int'(i) + 1) % DEPTH);
	endfunction

	function automatic idx_t idx_down(input idx_t i);
		return idx_t'((int'(i) + DEPTH - 1) % DEPTH);
	endfunction

	function automatic deque_result_t apply_request(input kind_t k, input val_t v);
		deque_result_t r;
		r = '0;
		r.status = STAT_DONE;
		if (k == KIND_PUSH_FRONT || k == KIND_PUSH_BACK) begin
			if (held == cnt_t'(DEPTH)) begin
				r.status = STAT_FULL;
			end else if (held == '0) begin
				slot_mem[head_idx] = v;
				tail_idx = head_idx;
				held = cnt_t'(1);
			end else if (k == KIND_PUSH_FRONT) begin
				head_idx = idx_down(head_idx);
				slot_mem[head_idx] = v;
				held = held + 1'b1;
			end else begin
				tail_idx = idx_up(tail_idx);
				slot_mem[tail_idx] = v;
				held = held + 1'b1;
			end
		end else if (held == '0) begin
			r.status = STAT_EMPTY;
		end else begin
			if (k == KIND_POP_FRONT) begin
				r.popped = slot_mem[head_idx];
				head_idx = idx_up(head_idx);
			end else begin
				r.popped = slot_mem[tail_idx];
				tail_idx = idx_down(tail_idx);
			end
			held = held - 1'b1;
			if (held == '0) begin
				head_idx = '0;
				tail_idx = '0;
			end
		end
		if (held != '0) begin
			r.front = slot_mem[head_idx];
			r.back  = slot_mem[tail_idx];
		end
		r.count = OUT_CNT_W'(held);
		r.empty = (held == '0);
		r.full  = (held == cnt_t'(DEPTH));
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_v, input logic [31:0] got);
		if (got !== exp_v) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got);
			err_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_idx = '0;
			tail_idx = '0;
			held     = '0;
			expected_q.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					$display("%0t: result transfer with nothing expected, expected none, got status %0d",
						$time, status);
					err_count++;
				end else begin
					want = expected_q.pop_front();
					result_count++;
					if (want.status != STAT_DONE)
						reject_count++;
					check_field("status", 32'(want.status), 32'(status));
					check_field("popped_value", want.popped, popped_value);
					check_field("front_value", want.front, front_value);
					check_field("back_value", want.back, back_value);
					check_field("entry_count", 32'(want.count), 32'(entry_count));
					check_field("is_empty", 32'(want.empty), 32'(is_empty));
					check_field("is_full", 32'(want.full), 32'(is_full));
				end
			end
			if (in_valid && !in_stall)
				expected_q.push_back(apply_request(kind, push_value));
		end
		errors       <= err_count;
		pending      <= expected_q.size();
		results_seen <= result_count;
		rejects_seen <= reject_count;
	end

endmodule

### test/circular_buffer_deque_core_test.sv
// Top of the deque core testbench: clock, reset, request stimulus with random gaps, random
// result stalls, a watchdog and the verdict. Depends on cbd_pkg, the core and its checker.
`timescale 1ns / 1ps

module circular_buffer_deque_core_test;
	import cbd_pkg::*;

	localparam int ITEMS      = 1350;
	localparam int IDLE_LIMIT = 4000;
	localparam int DIR_N      = 25;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	kind_t      kind;
	val_t       push_value;
	logic       out_valid;
	logic       out_stall;
	status_t    status;
	val_t       popped_value;
	val_t       front_value;
	val_t       back_value;
	logic [3:0] entry_count;
	logic       is_empty;
	logic       is_full;

	int errors;
	int pending;
	int results_seen;
	int rejects_seen;
	int sent;
	int idle_cycles;
	int stall_left;
	logic stall_quiet;
	logic gap_quiet;
	int push_pct;
	kind_t req_kind;

	kind_t dir_kind [DIR_N] = '{
		KIND_POP_FRONT, KIND_POP_BACK, KIND_PUSH_BACK, KIND_POP_FRONT, KIND_PUSH_FRONT,
		KIND_POP_BACK, KIND_PUSH_FRONT, KIND_PUSH_FRONT, KIND_PUSH_BACK, KIND_PUSH_FRONT,
		KIND_PUSH_BACK, KIND_PUSH_FRONT, KIND_PUSH_BACK, KIND_PUSH_FRONT, KIND_PUSH_BACK,
		KIND_PUSH_FRONT, KIND_POP_FRONT, KIND_POP_BACK, KIND_POP_BACK, KIND_POP_FRONT,
		KIND_POP_FRONT, KIND_POP_BACK, KIND_POP_BACK, KIND_POP_FRONT, KIND_POP_BACK
	};
	val_t dir_val [DIR_N] = '{
		32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000,
		32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h5555_5555, 32'hAAAA_AAAA,
		32'h0000_0001, 32'h1234_5678, 32'hFEDC_BA98, 32'h0F0F_0F0F, 32'h0000_0003,
		32'h0000_0004, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000,
		32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000
	};

	circular_buffer_deque_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.push_value   (push_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.popped_value (popped_value),
		.front_value  (front_value),
		.back_value   (back_value),
		.entry_count  (entry_count),
		.is_empty     (is_empty),
		.is_full      (is_full)
	);

	circular_buffer_deque_core_check i_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.push_value   (push_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.popped_value (popped_value),
		.front_value  (front_value),
		.back_value   (back_value),
		.entry_count  (entry_count),
		.is_empty     (is_empty),
		.is_full      (is_full),
		.errors       (errors),
		.pending      (pending),
		.results_seen (results_seen),
		.rejects_seen (rejects_seen)
	);

	always #1 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (gap_quiet || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic val_t random_value();
		case ($urandom_range(0, 11))
			0: return val_t'(32'h7FFF_FFFF);
			1: return val_t'(32'h8000_0000);
			2: return val_t'(32'hFFFF_FFFF);
			3: return val_t'(32'h0000_0000);
			default: return val_t'($urandom);
		endcase
	endfunction

	task automatic send(input kind_t k, input val_t v);
		in_valid   <= 1'b1;
		kind       <= k;
		push_value <= v;
		do @(posedge clk); while (in_stall);
		sent++;
	endtask

	task automatic idle(input int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	always @(posedge clk) begin
		if ($urandom_range(0, 199) == 0)
			stall_quiet <= ~stall_quiet;
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall  <= 1'b1;
		end else if (!stall_quiet && $urandom_range(0, 99) < 25) begin
			stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
			out_stall  <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Watchdog expired with %0d results outstanding.", pending);
			$display("circular_buffer_deque_core_test: errors");
			$finish;
		end
	end

	initial begin
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		kind        <= KIND_PUSH_FRONT;
		push_value  <= '0;
		out_stall   <= 1'b0;
		stall_left  <= 0;
		stall_quiet <= 1'b0;
		gap_quiet    = 1'b0;
		sent         = 0;
		idle_cycles <= 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_N; i++) begin
			send(dir_kind[i], dir_val[i]);
			idle(pick_gap());
		end
		drain();

		push_pct = 50;
		for (int n = 0; n < ITEMS; n++) begin
			if (n % 40 == 0) begin
				case ($urandom_range(0, 4))
					0: push_pct = 5;
					1: push_pct = 25;
					2: push_pct = 50;
					3: push_pct = 75;
					default: push_pct = 95;
				endcase
			end
			if (n % 150 == 0)
				gap_quiet = ($urandom_range(0, 3) == 0);
			if (n == ITEMS / 2)
				drain();
			if ($urandom_range(0, 99) < push_pct)
				req_kind = $urandom_range(0, 1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
			else
				req_kind = $urandom_range(0, 1) ? KIND_POP_BACK : KIND_POP_FRONT;
			send(req_kind, random_value());
			idle(pick_gap());
		end

		drain();
		repeat (10) @(posedge clk);
		$display("Sent %0d deque requests; %0d results checked, %0d of them rejected as full or empty.",
			sent, results_seen, rejects_seen);
		if (errors == 0 && pending == 0)
			$display("circular_buffer_deque_core_test: clean");
		else
			$display("circular_buffer_deque_core_test: errors");
		$finish;
	end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/cbd_pkg.sv
hw/rtl/cbd_ram.sv
hw/rtl/circular_buffer_deque_core.sv
hw/rtl/cbd_checker.sv
test/circular_buffer_deque_core_check.sv
test/circular_buffer_deque_core_test.sv
